>>> hw/rtl/periodic_timer_bank_assert.svh
// Assertion macros shared by the timer bank RTL.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

// The expression must hold at every clock edge out of reset.
`define PTB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("timer bank invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank sequence violated");

`endif

>>> hw/rtl/ptb_pkg.sv
package ptb_pkg;

  localparam int unsigned IDX_W      = 2;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DEF_TIMERS = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_START   = 3'd0,
    MODE_RESTART = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_ADVANCE = 3'd3,
    MODE_SERVICE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_PULL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] key;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ptb_cell.sv
module ptb_cell #(
  parameter int unsigned TIMERS = ptb_pkg::DEF_TIMERS,
  parameter int unsigned POS    = 0,
  parameter int unsigned LenW   = $clog2(TIMERS + 1)
) (
  input  logic                    clk_i,
  input  ptb_pkg::cell_ctrl_t     ctrl_i,
  input  logic [LenW-1:0]         len_i,
  input  logic [ptb_pkg::IDX_W-1:0] prev_id_i,
  input  logic [ptb_pkg::IDX_W-1:0] next_id_i,
  input  logic                    found_i,
  output logic [ptb_pkg::IDX_W-1:0] id_o,
  output logic                    found_o
);
  import ptb_pkg::*;

  logic [IDX_W-1:0] id_q, id_d;
  logic             in_list;
  logic             match;

  assign in_list = LenW'(POS) < len_i;
  assign match   = in_list && (id_q == ctrl_i.key);
  // Once the removed entry has been seen, every later cell takes its right neighbour.
  assign found_o = found_i | match;
  assign id_o    = id_q;

  always_comb begin
    case (ctrl_i.op)
      CELL_PUSH: id_d = prev_id_i;
      CELL_PULL: id_d = found_o ? next_id_i : id_q;
      CELL_ROT:  id_d = next_id_i;
      default:   id_d = id_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

>>> hw/rtl/ptb_chain.sv
module ptb_chain #(
  parameter int unsigned TIMERS = ptb_pkg::DEF_TIMERS,
  parameter int unsigned LenW   = $clog2(TIMERS + 1)
) (
  input  logic                      clk_i,
  input  ptb_pkg::cell_ctrl_t       ctrl_i,
  input  logic [LenW-1:0]           len_i,
  output logic [ptb_pkg::IDX_W-1:0] head_id_o,
  output logic                      found_o
);
  import ptb_pkg::*;

  logic [IDX_W-1:0] ids   [TIMERS];
  logic             found [TIMERS+1];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    logic [IDX_W-1:0] prev_id;
    logic [IDX_W-1:0] next_id;

    if (i == 0) begin : g_first
      assign prev_id = ctrl_i.key;
    end else begin : g_inner
      assign prev_id = ids[i-1];
    end

    // The far end wraps to the head so that a full rotation restores the order.
    if (i == TIMERS - 1) begin : g_last
      assign next_id = ids[0];
    end else begin : g_body
      assign next_id = ids[i+1];
    end

    ptb_cell #(
      .TIMERS (TIMERS),
      .POS    (i),
      .LenW   (LenW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .len_i     (len_i),
      .prev_id_i (prev_id),
      .next_id_i (next_id),
      .found_i   (found[i]),
      .id_o      (ids[i]),
      .found_o   (found[i+1])
    );
  end

  assign head_id_o = ids[0];
  assign found_o   = found[TIMERS];

endmodule

>>> hw/rtl/periodic_timer_bank.sv
// Control, advance and zero-tick service items are accepted back to back.
// A service item with a nonzero tick is accepted, then the scan state visits each chain
// position as the order rotates past the head cell; flush hands over any held result.
// The scan stalls while an earlier result waits in the output register.
// Asynchronous active-low reset stops all timers, clears the tick and the periods.
`include "periodic_timer_bank_assert.svh"

module periodic_timer_bank #(
  parameter int unsigned TIMERS = ptb_pkg::DEF_TIMERS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ptb_pkg::TICK_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptb_pkg::MODE_W-1:0]    mode_i,
  input  logic [ptb_pkg::IDX_W-1:0]     timer_index_i,
  input  logic [ptb_pkg::TICK_W-1:0]    tick_increment_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptb_pkg::IDX_W-1:0]     expired_timer_o,
  output logic [ptb_pkg::TICK_W-1:0]    tick_now_o,
  output logic                          last_o
);
  import ptb_pkg::*;

  localparam int unsigned LenW = $clog2(TIMERS + 1);
  localparam int unsigned SelW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  state_e              state_q, state_d;
  logic [TICK_W-1:0]   tick_q;
  logic [LenW-1:0]     len_q;
  logic [TIMERS-1:0]   active_q;
  logic [TICK_W-1:0]   begin_q  [TIMERS];
  logic [TICK_W-1:0]   period_q [TIMERS];
  logic [SelW-1:0]     scan_q;
  logic                pend_valid_q;
  logic [IDX_W-1:0]    pend_id_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_id_q;
  logic [TICK_W-1:0]   out_tick_q;
  logic                out_last_q;

  cell_ctrl_t          cell_ctrl;
  logic [IDX_W-1:0]    head_id;
  logic [SelW-1:0]     head_sel;
  logic                found;
  logic                accept;
  logic                idx_ok;
  logic [SelW-1:0]     t_sel;
  logic                cfg_ok;
  logic                head_in_list;
  logic [TICK_W-1:0]   elapsed;
  logic                hit;
  logic                out_free;
  logic                advance;
  logic                push;
  logic                push_last;
  logic                scan_end;

  assign accept   = in_valid_i && in_ready_o;
  assign idx_ok   = {1'b0, timer_index_i} < (IDX_W + 1)'(TIMERS);
  assign t_sel    = timer_index_i[SelW-1:0];
  assign cfg_ok   = {1'b0, cfg_index_i} < (CFG_IDX_W + 1)'(TIMERS);
  assign head_sel = head_id[SelW-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign scan_end = scan_q == SelW'(TIMERS - 1);

  assign head_in_list = LenW'(scan_q) < len_q;
  assign elapsed      = tick_q - begin_q[head_sel];
  assign hit          = head_in_list && (elapsed >= period_q[head_sel]);

  ptb_chain #(
    .TIMERS (TIMERS),
    .LenW   (LenW)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .len_i     (len_q),
    .head_id_o (head_id),
    .found_o   (found)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (mode_e'(mode_i) == MODE_SERVICE) && (tick_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && scan_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready_o    = 1'b0;
    advance       = 1'b0;
    push          = 1'b0;
    push_last     = 1'b0;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.key = timer_index_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && idx_ok) begin
          case (mode_e'(mode_i))
            MODE_START, MODE_RESTART: begin
              if (!active_q[t_sel]) begin
                cell_ctrl.op = CELL_PUSH;
              end
            end
            MODE_STOP: cell_ctrl.op = CELL_PULL;
            default:   cell_ctrl.op = CELL_HOLD;
          endcase
        end
      end
      ST_SCAN: begin
        // A second expiry needs room to move the held one out first.
        advance      = !(hit && pend_valid_q && !out_free);
        cell_ctrl.op = advance ? CELL_ROT : CELL_HOLD;
        push         = advance && hit && pend_valid_q;
      end
      ST_FLUSH: begin
        push      = pend_valid_q && out_free;
        push_last = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_q       <= '0;
      len_q        <= '0;
      active_q     <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < TIMERS; i++) begin
        begin_q[i]  <= '0;
        period_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i && cfg_ok) begin
        period_q[cfg_index_i[SelW-1:0]] <= cfg_wdata_i;
      end

      if (state_q == ST_IDLE && accept) begin
        case (mode_e'(mode_i))
          MODE_START, MODE_RESTART: begin
            if (idx_ok) begin
              if (!active_q[t_sel]) begin
                begin_q[t_sel]  <= tick_q;
                active_q[t_sel] <= 1'b1;
                len_q           <= len_q + LenW'(1);
              end else if (mode_e'(mode_i) == MODE_RESTART) begin
                begin_q[t_sel] <= tick_q;
              end
            end
          end
          MODE_STOP: begin
            if (idx_ok && found) begin
              active_q[t_sel] <= 1'b0;
              len_q           <= len_q - LenW'(1);
            end
          end
          MODE_ADVANCE: tick_q <= tick_q + tick_increment_i;
          MODE_SERVICE: begin
            scan_q       <= '0;
            pend_valid_q <= 1'b0;
          end
          default: tick_q <= tick_q;
        endcase
      end

      if (state_q == ST_SCAN && advance) begin
        scan_q <= scan_q + SelW'(1);
        if (hit) begin
          begin_q[head_sel] <= tick_q;
          pend_valid_q      <= 1'b1;
        end
      end

      if (state_q == ST_FLUSH && push) begin
        pend_valid_q <= 1'b0;
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && advance && hit) begin
      pend_id_q <= head_id;
    end
    if (push) begin
      out_id_q   <= pend_id_q;
      out_tick_q <= tick_q;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign expired_timer_o = out_id_q;
  assign tick_now_o      = out_tick_q;
  assign last_o          = out_last_q;

  `PTB_ASSERT_ALWAYS(a_len_matches_active, clk_i, rst_ni, $countones(active_q) == 32'(len_q))
  `PTB_ASSERT_ALWAYS(a_len_in_range, clk_i, rst_ni, len_q <= LenW'(TIMERS))
  `PTB_ASSERT_NEXT(a_tick_frozen_in_pass, clk_i, rst_ni, state_q != ST_IDLE, $stable(tick_q))
  `PTB_ASSERT_NEXT(a_service_starts_scan, clk_i, rst_ni, accept && (mode_i == MODE_SERVICE) && (tick_q != '0), state_q == ST_SCAN)

endmodule

>>> verif/tb.sv
module tb;
  import ptb_pkg::*;

  localparam int unsigned NUM_TIMERS = DEF_TIMERS;
  localparam int unsigned REG_PERIOD_T0 = 0;
  localparam int unsigned REG_PERIOD_T1 = 1;
  localparam int unsigned REG_PERIOD_T2 = 2;
  localparam int unsigned REG_PERIOD_T3 = 3;
  localparam int unsigned SETTLE_CYCLES = NUM_TIMERS + 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] inc;
  } timer_cmd_t;

  typedef struct {
    logic [IDX_W-1:0]  timer;
    logic [TICK_W-1:0] tick;
    logic              last;
  } expiry_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TICK_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [MODE_W-1:0]    mode_i = '0;
  logic [IDX_W-1:0]     timer_index_i = '0;
  logic [TICK_W-1:0]    tick_increment_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [IDX_W-1:0]     expired_timer_o;
  logic [TICK_W-1:0]    tick_now_o;
  logic                 last_o;

  periodic_timer_bank #(.TIMERS(NUM_TIMERS)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .timer_index_i    (timer_index_i),
    .tick_increment_i (tick_increment_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .expired_timer_o  (expired_timer_o),
    .tick_now_o       (tick_now_o),
    .last_o           (last_o)
  );

  // Shadow copy of the timer bank, advanced at every input transfer.
  logic [TICK_W-1:0] period_shadow [NUM_TIMERS];
  logic [TICK_W-1:0] stamp_shadow [NUM_TIMERS];
  logic              running [NUM_TIMERS];
  logic [TICK_W-1:0] tick_shadow;
  logic [IDX_W-1:0]  order_q [$];

  timer_cmd_t  cmd_q [$];
  expiry_t     expiry_q [$];
  timer_cmd_t  next_cmd;
  expiry_t     got_expiry;
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [TICK_W-1:0] want,
                                 input logic [TICK_W-1:0] seen);
    if (error_count < 40) begin
      $display("mismatch on %s: expected %0h, got %0h (result %0d)", what, want, seen,
               got_count);
    end
    error_count++;
  endtask

  task automatic arm_timer(input logic [IDX_W-1:0] idx);
    if (running[idx] || order_q.size() >= NUM_TIMERS) begin
      return;
    end
    stamp_shadow[idx] = tick_shadow;
    order_q.push_front(idx);
    running[idx] = 1'b1;
  endtask

  task automatic apply_timer_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                                 input logic [TICK_W-1:0] inc);
    expiry_t           hits [$];
    expiry_t           hit;
    logic [IDX_W-1:0]  id;
    logic [TICK_W-1:0] elapsed;
    int                pos;
    case (mode)
      MODE_ADVANCE: begin
        tick_shadow += inc;
      end
      MODE_START: begin
        arm_timer(idx);
      end
      MODE_RESTART: begin
        if (running[idx]) begin
          stamp_shadow[idx] = tick_shadow;
        end else begin
          arm_timer(idx);
        end
      end
      MODE_STOP: begin
        pos = -1;
        foreach (order_q[k]) begin
          if (order_q[k] == idx) pos = k;
        end
        if (running[idx] && pos >= 0) begin
          order_q.delete(pos);
          running[idx] = 1'b0;
        end
      end
      MODE_SERVICE: begin
        // A pass with the tick still at zero finds nothing, whatever the periods.
        if (tick_shadow != '0) begin
          foreach (order_q[k]) begin
            id = order_q[k];
            elapsed = tick_shadow - stamp_shadow[id];
            if (elapsed >= period_shadow[id]) begin
              stamp_shadow[id] = tick_shadow;
              hit.timer = id;
              hit.tick = tick_shadow;
              hit.last = 1'b0;
              hits.push_back(hit);
            end
          end
          if (hits.size() != 0) hits[hits.size()-1].last = 1'b1;
          foreach (hits[k]) expiry_q.push_back(hits[k]);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [TICK_W-1:0] inc);
    timer_cmd_t c;
    c.mode = mode;
    c.idx = idx;
    c.inc = inc;
    cmd_q.push_back(c);
  endtask

  // Mostly start, advance and service traffic so that timers really expire,
  // with some stops, wide advances and unused codes mixed in.
  task automatic queue_random_cmd(input int unsigned step_max);
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    idx = IDX_W'($urandom_range(NUM_TIMERS - 1));
    if (pick < 12) begin
      queue_cmd(MODE_START, idx, $urandom());
    end else if (pick < 18) begin
      queue_cmd(MODE_RESTART, idx, $urandom());
    end else if (pick < 24) begin
      queue_cmd(MODE_STOP, idx, $urandom());
    end else if (pick < 54) begin
      queue_cmd(MODE_ADVANCE, idx, $urandom_range(step_max));
    end else if (pick < 58) begin
      queue_cmd(MODE_ADVANCE, idx, $urandom());
    end else if (pick < 96) begin
      queue_cmd(MODE_SERVICE, idx, $urandom());
    end else begin
      queue_cmd(MODE_W'($urandom_range(7, 5)), idx, $urandom());
    end
  endtask

  task automatic write_reg(input int unsigned index, input logic [TICK_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(index);
    cfg_wdata_i <= value;
    period_shadow[index] = value;
  endtask

  task automatic set_periods(input logic [TICK_W-1:0] p0, input logic [TICK_W-1:0] p1,
                             input logic [TICK_W-1:0] p2, input logic [TICK_W-1:0] p3);
    write_reg(REG_PERIOD_T0, p0);
    write_reg(REG_PERIOD_T1, p1);
    write_reg(REG_PERIOD_T2, p2);
    write_reg(REG_PERIOD_T3, p3);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued command has been transferred and every expiry has
  // arrived, then waits on long enough for a service pass that finds nothing.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid_i || expiry_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned step_max);
    @(negedge clk_i);
    repeat (count) queue_random_cmd(step_max);
    wait_idle();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= '0;
      timer_index_i <= '0;
      tick_increment_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_timer_cmd(mode_i, timer_index_i, tick_increment_i);
        sent_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_q.size() != 0 &&
            ((sent_count >= 200 && sent_count < 260) || $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= next_cmd.mode;
          timer_index_i <= next_cmd.idx;
          tick_increment_i <= next_cmd.inc;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // One long hold-off lets the bank back up and stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && got_count >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expiry_q.size() == 0) begin
          report_mismatch("unexpected expiry, timer", '0, TICK_W'(expired_timer_o));
        end else begin
          got_expiry = expiry_q.pop_front();
          if (expired_timer_o !== got_expiry.timer) begin
            report_mismatch("expired_timer", TICK_W'(got_expiry.timer),
                            TICK_W'(expired_timer_o));
          end
          if (tick_now_o !== got_expiry.tick) begin
            report_mismatch("tick_now", got_expiry.tick, tick_now_o);
          end
          if (last_o !== got_expiry.last) begin
            report_mismatch("last", TICK_W'(got_expiry.last), TICK_W'(last_o));
          end
        end
        got_count++;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (got_count >= 120 && got_count < 170) ||
                       ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned spins;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      period_shadow[k] = '0;
      stamp_shadow[k] = '0;
      running[k] = 1'b0;
    end
    tick_shadow = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_periods(32'd0, 32'd3, 32'd8, 32'hFFFF_FFFF);
    @(negedge clk_i);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_START, 2'd0, 32'd0);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_START, 2'd1, 32'd0);
    queue_cmd(MODE_START, 2'd2, 32'd0);
    queue_cmd(MODE_START, 2'd3, 32'd0);
    queue_cmd(MODE_START, 2'd1, 32'd0);
    queue_cmd(MODE_ADVANCE, 2'd0, 32'd3);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_STOP, 2'd2, 32'd0);
    queue_cmd(MODE_STOP, 2'd2, 32'd0);
    queue_cmd(MODE_RESTART, 2'd1, 32'd0);
    queue_cmd(MODE_RESTART, 2'd2, 32'd0);
    queue_cmd(MODE_W'(5), 2'd3, 32'hFFFF_FFFF);
    queue_cmd(MODE_W'(6), 2'd3, 32'hFFFF_FFFF);
    queue_cmd(MODE_W'(7), 2'd0, 32'd0);
    // The tick wraps past zero here, so elapsed time must be taken modulo 2^32.
    queue_cmd(MODE_ADVANCE, 2'd3, 32'hFFFF_FFFF);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_ADVANCE, 2'd0, 32'h8000_0000);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_STOP, 2'd0, 32'd0);
    queue_cmd(MODE_SERVICE, 2'd0, 32'd0);
    queue_cmd(MODE_ADVANCE, 2'd0, 32'd0);
    queue_cmd(MODE_SERVICE, 2'd3, 32'hFFFF_FFFF);
    wait_idle();

    set_periods($urandom_range(20), $urandom_range(20), $urandom_range(20),
                $urandom_range(20));
    run_random(90, 8);
    set_periods(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
    run_random(60, 4);
    set_periods($urandom(), $urandom(), $urandom_range(50), $urandom_range(50));
    run_random(80, 16);
    set_periods($urandom_range(12), $urandom_range(12), $urandom_range(12),
                $urandom_range(12));
    @(negedge clk_i);
    repeat (110) queue_random_cmd(6);

    spins = 0;
    while ((cmd_q.size() != 0 || in_valid_i || expiry_q.size() != 0) && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (expiry_q.size() != 0) begin
      report_mismatch("missing expiries, count", '0, TICK_W'(expiry_q.size()));
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_cell.sv
hw/rtl/ptb_chain.sv
hw/rtl/periodic_timer_bank.sv
verif/tb.sv
